### sv/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; each macro wraps one concurrent assertion with reset disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in the same cycle as the consequent
`define GCRC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("gcrc checker: same-cycle property failed");

// consequent must hold in the cycle after the antecedent
`define GCRC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("gcrc checker: next-cycle property failed");

`endif

### sv/gcrc_pkg.sv
// shared types and constants for the graph cycle rank counter
// no dependencies; used by the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package gcrc_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CFG_W     = 7;
  localparam int CNT_W     = 16;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(MAX_NODES);
  localparam logic [CNT_W-1:0] CYCLE_MAX      = {CNT_W{1'b1}};

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RDB,
    S_CMP,
    S_SWEEP
  } state_t;

endpackage

`default_nettype wire

### sv/gcrc_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module gcrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### sv/graph_cycle_rank_counter_core.sv
// graph cycle rank counter: component labels in a ram, merge by relabelling sweep
// depends on gcrc_pkg and gcrc_ram
`timescale 1ns / 1ps
`default_nettype none

// Counts independent cycles (edges - nodes + components) of an undirected
// multigraph fed one edge per item. An item is taken when start is high and
// busy is low; its result shows on out_cycle_count/out_bad_node for exactly
// one cycle with out_valid high and cannot be held off by the receiver.
// Clear commands and edges with a node index not below node_count are
// answered straight from idle and leave busy low. A valid edge reads both
// end labels from the label ram; if the labels match the count is bumped
// and the result follows, otherwise a relabelling sweep reads every label
// ram entry, one per cycle, and rewrites those holding the second label.
// The sweep over the single-port-read label ram sets the rate.
// Labels reset to self-labels through per-entry valid bits, so no clearing
// pass is needed after reset or a clear command.
module graph_cycle_rank_counter_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_command,
  input  wire logic [gcrc_pkg::NODE_W-1:0] in_first_node,
  input  wire logic [gcrc_pkg::NODE_W-1:0] in_second_node,
  output logic                             out_valid,
  output logic      [gcrc_pkg::CNT_W-1:0]  out_cycle_count,
  output logic                             out_bad_node,
  input  wire logic                        cfg_we,
  input  wire logic [gcrc_pkg::CFG_W-1:0]  cfg_wdata
);

  gcrc_pkg::state_t state_r, state_nxt;

  logic [gcrc_pkg::NODE_W-1:0]  raddr, raddr_r;
  logic [gcrc_pkg::NODE_W-1:0]  b_r, b_nxt;
  logic [gcrc_pkg::NODE_W-1:0]  la_r, la_nxt;
  logic [gcrc_pkg::NODE_W-1:0]  lb_r, lb_nxt;
  logic [gcrc_pkg::CNT_W-1:0]   cycles_r, cycles_nxt;
  logic [gcrc_pkg::MAX_NODES-1:0] vld_r, vld_nxt;
  logic [gcrc_pkg::CFG_W-1:0]   node_count_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [gcrc_pkg::CNT_W-1:0]   out_cnt_r, out_cnt_nxt;
  logic                         out_bad_r, out_bad_nxt;

  logic                         we;
  logic [gcrc_pkg::NODE_W-1:0]  ram_q;
  logic [gcrc_pkg::NODE_W-1:0]  lbl_eff;
  logic                         bad_idx;
  logic [gcrc_pkg::CNT_W-1:0]   cycles_inc;

  gcrc_ram #(
    .WIDTH (gcrc_pkg::NODE_W),
    .DEPTH (gcrc_pkg::MAX_NODES)
  ) u_label_ram (
    .clk   (clk),
    .we    (we),
    .waddr (raddr_r),
    .wdata (la_r),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // an entry never written since reset or clear carries its own index
  assign lbl_eff = vld_r[raddr_r] ? ram_q : raddr_r;

  assign bad_idx = ({1'b0, in_first_node} >= node_count_r) ||
                   ({1'b0, in_second_node} >= node_count_r);

  assign cycles_inc = (cycles_r == gcrc_pkg::CYCLE_MAX) ? cycles_r
                                                       : cycles_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    raddr         = raddr_r;
    b_nxt         = b_r;
    la_nxt        = la_r;
    lb_nxt        = lb_r;
    cycles_nxt    = cycles_r;
    vld_nxt       = vld_r;
    we            = 1'b0;
    out_valid_nxt = 1'b0;
    out_cnt_nxt   = out_cnt_r;
    out_bad_nxt   = out_bad_r;
    case (state_r)
      gcrc_pkg::S_IDLE: begin
        if (start) begin
          if (in_command == gcrc_pkg::CMD_CLEAR) begin
            vld_nxt       = '0;
            cycles_nxt    = '0;
            out_valid_nxt = 1'b1;
            out_cnt_nxt   = '0;
            out_bad_nxt   = 1'b0;
          end else if (bad_idx) begin
            out_valid_nxt = 1'b1;
            out_cnt_nxt   = cycles_r;
            out_bad_nxt   = 1'b1;
          end else begin
            raddr     = in_first_node;
            b_nxt     = in_second_node;
            state_nxt = gcrc_pkg::S_RDB;
          end
        end
      end
      gcrc_pkg::S_RDB: begin
        la_nxt    = lbl_eff;
        raddr     = b_r;
        state_nxt = gcrc_pkg::S_CMP;
      end
      gcrc_pkg::S_CMP: begin
        if (lbl_eff == la_r) begin
          cycles_nxt    = cycles_inc;
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = cycles_inc;
          out_bad_nxt   = 1'b0;
          state_nxt     = gcrc_pkg::S_IDLE;
        end else begin
          lb_nxt    = lbl_eff;
          raddr     = '0;
          state_nxt = gcrc_pkg::S_SWEEP;
        end
      end
      gcrc_pkg::S_SWEEP: begin
        // entry raddr_r is checked and, if it holds the second label, rewritten while the next one is read
        if (lbl_eff == lb_r) begin
          we               = 1'b1;
          vld_nxt[raddr_r] = 1'b1;
        end
        raddr = raddr_r + 1'b1;
        if (raddr_r == gcrc_pkg::NODE_W'(gcrc_pkg::MAX_NODES - 1)) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = cycles_r;
          out_bad_nxt   = 1'b0;
          state_nxt     = gcrc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = gcrc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gcrc_pkg::S_IDLE;
      cycles_r     <= '0;
      vld_r        <= '0;
      node_count_r <= gcrc_pkg::NODE_COUNT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cycles_r    <= cycles_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    raddr_r   <= raddr;
    b_r       <= b_nxt;
    la_r      <= la_nxt;
    lb_r      <= lb_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_bad_r <= out_bad_nxt;
  end

  assign busy            = (state_r != gcrc_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_cycle_count = out_cnt_r;
  assign out_bad_node    = out_bad_r;

endmodule

`default_nettype wire

### sv/gcrc_checker.sv
// port-level checker for the graph cycle rank counter, bound to the top level
// depends on gcrc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gcrc_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        in_command,
  input wire logic                        out_valid,
  input wire logic [gcrc_pkg::CNT_W-1:0]  out_cycle_count,
  input wire logic                        out_bad_node
);

  logic accept;

  assign accept = start && !busy;

  // a clear item answers in the next cycle with a zero count and no flag
  `GCRC_ASSERT_NXT(a_clear_result, clk, rst_n, accept && in_command == gcrc_pkg::CMD_CLEAR, out_valid && out_cycle_count == '0 && !out_bad_node)

  // an accepted insert either answers at once or keeps the block busy
  `GCRC_ASSERT_NXT(a_insert_progress, clk, rst_n, accept && in_command == gcrc_pkg::CMD_INSERT, busy || out_valid)

  // a result only ever comes out with the block ready for the next item
  `GCRC_ASSERT_IMP(a_result_idle, clk, rst_n, out_valid, !busy)

  // finishing an edge always delivers its result
  `GCRC_ASSERT_IMP(a_done_delivers, clk, rst_n, $fell(busy) && $past(rst_n), out_valid && !out_bad_node)

endmodule

bind graph_cycle_rank_counter_core gcrc_checker u_gcrc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_command      (in_command),
  .out_valid       (out_valid),
  .out_cycle_count (out_cycle_count),
  .out_bad_node    (out_bad_node)
);

`default_nettype wire

### tb/cycle_rank_checker.sv
// checker for the graph cycle rank counter: watches the item, result and config ports,
// predicts each result and compares it field by field
// depends on gcrc_pkg
`timescale 1ns / 1ps

module cycle_rank_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic                        busy,
  input  wire logic                        in_command,
  input  wire logic [gcrc_pkg::NODE_W-1:0] in_first_node,
  input  wire logic [gcrc_pkg::NODE_W-1:0] in_second_node,
  input  wire logic                        out_valid,
  input  wire logic [gcrc_pkg::CNT_W-1:0]  out_cycle_count,
  input  wire logic                        out_bad_node,
  input  wire logic                        cfg_we,
  input  wire logic [gcrc_pkg::CFG_W-1:0]  cfg_wdata,
  output int                               fail_count,
  output int                               outstanding
);

  typedef struct packed {
    logic [gcrc_pkg::CNT_W-1:0] count;
    logic                       bad;
  } rank_result_t;

  rank_result_t                expected_ranks[$];
  logic [gcrc_pkg::NODE_W-1:0] comp_label[gcrc_pkg::MAX_NODES];
  logic [gcrc_pkg::CNT_W-1:0]  cycle_total;
  logic [gcrc_pkg::CFG_W-1:0]  node_count_q;

  function automatic void reset_graph();
    for (int i = 0; i < gcrc_pkg::MAX_NODES; i++) comp_label[i] = gcrc_pkg::NODE_W'(i);
    cycle_total = '0;
  endfunction

  // updates the graph copy with one item and returns the count and bad-node flag it should report
  function automatic rank_result_t apply_edge(gcrc_pkg::cmd_t cmd,
                                              logic [gcrc_pkg::NODE_W-1:0] a,
                                              logic [gcrc_pkg::NODE_W-1:0] b);
    rank_result_t                r;
    int                          lim;
    logic [gcrc_pkg::NODE_W-1:0] la;
    logic [gcrc_pkg::NODE_W-1:0] lb;
    r.bad = 1'b0;
    if (cmd == gcrc_pkg::CMD_CLEAR) begin
      reset_graph();
    end else begin
      lim = (int'(node_count_q) < gcrc_pkg::MAX_NODES) ? int'(node_count_q)
                                                       : gcrc_pkg::MAX_NODES;
      if (int'(a) >= lim || int'(b) >= lim) begin
        r.bad = 1'b1;
      end else begin
        la = comp_label[a];
        lb = comp_label[b];
        if (la == lb) begin
          if (cycle_total != gcrc_pkg::CYCLE_MAX) cycle_total = cycle_total + 1'b1;
        end else begin
          for (int i = 0; i < gcrc_pkg::MAX_NODES; i++)
            if (comp_label[i] == lb) comp_label[i] = la;
        end
      end
    end
    r.count = cycle_total;
    return r;
  endfunction

  task automatic flag_error(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: cycle rank mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    rank_result_t want;
    rank_result_t next_rank;
    if (!rst_n) begin
      reset_graph();
      node_count_q = gcrc_pkg::NODE_COUNT_RST;
      expected_ranks.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) node_count_q = cfg_wdata;
      // results are registered, so the oldest expectation is settled before a new item
      if (out_valid) begin
        if (expected_ranks.size() == 0) begin
          flag_error($sformatf("result count=%0d bad=%0b with no item outstanding",
                               out_cycle_count, out_bad_node));
        end else begin
          want = expected_ranks.pop_front();
          if (out_cycle_count !== want.count)
            flag_error($sformatf("cycle_count expected %0d got %0d",
                                 want.count, out_cycle_count));
          if (out_bad_node !== want.bad)
            flag_error($sformatf("bad_node expected %0b got %0b", want.bad, out_bad_node));
        end
      end
      if (start && !busy) begin
        next_rank = apply_edge(gcrc_pkg::cmd_t'(in_command), in_first_node,
                               in_second_node);
        expected_ranks = {expected_ranks, next_rank};
      end
    end
    outstanding = expected_ranks.size();
  end

endmodule

### tb/graph_cycle_rank_counter_core_tb.sv
// top of the graph cycle rank counter testbench: clock, reset, item and config stimulus
// depends on gcrc_pkg, graph_cycle_rank_counter_core and cycle_rank_checker
`timescale 1ns / 1ps

module graph_cycle_rank_counter_core_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 100;

  logic                        clk;
  logic                        rst_n          = 1'b0;
  logic                        start          = 1'b0;
  logic                        busy;
  logic                        in_command     = 1'b0;
  logic [gcrc_pkg::NODE_W-1:0] in_first_node  = '0;
  logic [gcrc_pkg::NODE_W-1:0] in_second_node = '0;
  logic                        out_valid;
  logic [gcrc_pkg::CNT_W-1:0]  out_cycle_count;
  logic                        out_bad_node;
  logic                        cfg_we         = 1'b0;
  logic [gcrc_pkg::CFG_W-1:0]  cfg_wdata      = '0;

  int fail_count;
  int outstanding;
  int stall_cycles = 0;
  int nodes_now    = gcrc_pkg::MAX_NODES;

  graph_cycle_rank_counter_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_first_node  (in_first_node),
    .in_second_node (in_second_node),
    .out_valid      (out_valid),
    .out_cycle_count(out_cycle_count),
    .out_bad_node   (out_bad_node),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  cycle_rank_checker rank_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_first_node  (in_first_node),
    .in_second_node (in_second_node),
    .out_valid      (out_valid),
    .out_cycle_count(out_cycle_count),
    .out_bad_node   (out_bad_node),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog on cycles with neither an item nor a result taken
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("graph_cycle_rank_counter_core_tb NOT OK");
      $finish;
    end
  end

  // busy only moves on rising edges, so it is read at the falling edge
  task automatic push_edge(gcrc_pkg::cmd_t cmd, int a, int b, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_command     <= cmd;
    in_first_node  <= gcrc_pkg::NODE_W'(a);
    in_second_node <= gcrc_pkg::NODE_W'(b);
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic set_node_count(int v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= gcrc_pkg::CFG_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    nodes_now = v;
  endtask

  // mostly edges inside the valid range so components merge and cycles build up
  task automatic random_edge(int idle_pct);
    int lim;
    int roll;
    int a;
    int b;
    lim  = (nodes_now > gcrc_pkg::MAX_NODES) ? gcrc_pkg::MAX_NODES : nodes_now;
    a    = $urandom_range(gcrc_pkg::MAX_NODES - 1);
    b    = $urandom_range(gcrc_pkg::MAX_NODES - 1);
    if ($urandom_range(99) < 4) wait_drained();
    roll = $urandom_range(99);
    if (roll < 3) begin
      push_edge(gcrc_pkg::CMD_CLEAR, a, b, idle_pct);
    end else if (roll < 12 || lim == 0) begin
      push_edge(gcrc_pkg::CMD_INSERT, a, b, idle_pct);
    end else begin
      a = $urandom_range(lim - 1);
      if (roll >= 25) b = $urandom_range(lim - 1);
      else b = a;
      push_edge(gcrc_pkg::CMD_INSERT, a, b, idle_pct);
    end
  endtask

  initial begin
    int idle_pct;
    int nodes;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // self-loop, parallel edge, merges of larger components, clear with junk fields
    push_edge(gcrc_pkg::CMD_INSERT, 0, 0, 13);
    push_edge(gcrc_pkg::CMD_INSERT, 0, 63, 13);
    push_edge(gcrc_pkg::CMD_INSERT, 63, 0, 13);
    push_edge(gcrc_pkg::CMD_INSERT, 63, 63, 13);
    push_edge(gcrc_pkg::CMD_INSERT, 1, 2, 13);
    push_edge(gcrc_pkg::CMD_INSERT, 2, 1, 13);
    push_edge(gcrc_pkg::CMD_INSERT, 2, 63, 13);
    push_edge(gcrc_pkg::CMD_INSERT, 1, 0, 13);
    push_edge(gcrc_pkg::CMD_CLEAR, 63, 63, 13);
    push_edge(gcrc_pkg::CMD_INSERT, 62, 1, 13);
    // single node, then no valid node at all
    set_node_count(1);
    push_edge(gcrc_pkg::CMD_INSERT, 0, 0, 13);
    push_edge(gcrc_pkg::CMD_INSERT, 0, 1, 13);
    push_edge(gcrc_pkg::CMD_INSERT, 63, 0, 13);
    set_node_count(0);
    push_edge(gcrc_pkg::CMD_INSERT, 0, 0, 13);
    // above the node limit; graph survives the write
    set_node_count(127);
    push_edge(gcrc_pkg::CMD_INSERT, 1, 62, 13);
    push_edge(gcrc_pkg::CMD_INSERT, 63, 62, 13);
    push_edge(gcrc_pkg::CMD_INSERT, 63, 1, 13);
    set_node_count(2);
    push_edge(gcrc_pkg::CMD_INSERT, 1, 0, 13);
    push_edge(gcrc_pkg::CMD_INSERT, 2, 0, 13);
    push_edge(gcrc_pkg::CMD_INSERT, 0, 2, 13);
    push_edge(gcrc_pkg::CMD_CLEAR, 42, 21, 13);

    for (int phase = 0; phase < 6; phase++) begin
      idle_pct = (phase < 2) ? 13 : (phase < 4) ? 70 : 0;
      case (phase)
        0: nodes = 64;
        1: nodes = 5;
        2: nodes = 127;
        3: nodes = 2;
        4: nodes = $urandom_range(1, 127);
        default: nodes = 40;
      endcase
      set_node_count(nodes);
      for (int i = 0; i < PHASE_ITEMS; i++) random_edge(idle_pct);
    end

    // merge two nodes, close the cycle, then clear back to back
    set_node_count(64);
    push_edge(gcrc_pkg::CMD_CLEAR, 0, 0, 0);
    push_edge(gcrc_pkg::CMD_INSERT, 0, 1, 0);
    push_edge(gcrc_pkg::CMD_INSERT, 1, 0, 0);
    push_edge(gcrc_pkg::CMD_CLEAR, 0, 0, 0);

    wait_drained();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("graph_cycle_rank_counter_core_tb OK");
    else
      $display("graph_cycle_rank_counter_core_tb NOT OK");
    $finish;
  end

endmodule
